// ===== rtl/btcs_pkg.sv =====
// Shared types and constants of the bound table cluster store.
// No dependencies.
`default_nettype none
package btcs_pkg;
    localparam int unsigned ENTRIES_DEF = 4096;

    typedef enum logic [1:0] {
        ACT_PROBE = 2'd0,
        ACT_UPPER = 2'd1,
        ACT_LOWER = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    // One stored slot.
    typedef struct packed {
        logic [31:0]        tag;
        logic [15:0]        date;
        logic [15:0]        mv;
        logic signed [15:0] lower;
        logic signed [15:0] upper;
        logic [7:0]         ldep;
        logic [7:0]         udep;
    } entry_t;

    // One classified request travelling from front to back.
    typedef struct packed {
        action_t            act;
        logic [31:0]        idx;
        logic [31:0]        tag;
        logic signed [15:0] value;
        logic [7:0]         depth;
        logic [15:0]        mv;
    } req_t;

    // One result item.
    typedef struct packed {
        logic               hit;
        logic [15:0]        mv;
        logic signed [15:0] lower;
        logic signed [15:0] upper;
        logic [7:0]         ldep;
        logic [7:0]         udep;
    } res_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_WRITE
    } bstate_t;
endpackage
`default_nettype wire

// ===== rtl/btcs_front.sv =====
// Front part: accepts input transfers and queues them as classified requests.
// Depends on btcs_pkg.
`default_nettype none
module btcs_front
    import btcs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  in_action,
    input  wire logic [63:0] in_key,
    input  wire logic [15:0] in_value,
    input  wire logic [7:0]  in_depth,
    input  wire logic [15:0] in_move,
    output logic             q_valid,
    input  wire logic        q_ready,
    output req_t             q_req
);
    // Two-entry queue.
    req_t        mem_reg [2];
    logic [0:0]  wp_reg, rp_reg;
    logic [1:0]  cnt_reg;
    req_t        r;
    logic        push, pop;

    always_comb
    begin
        r.act   = action_t'(in_action);
        r.idx   = in_key[63:32];
        r.tag   = in_key[31:0];
        r.value = in_value;
        r.depth = in_depth;
        r.mv    = in_move;
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_req    = mem_reg[rp_reg];

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= r;
        end
    end

    // Queue pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

// ===== rtl/btcs_back.sv =====
// Back part: cluster memory, lookup, replacement and update, result register.
// Depends on btcs_pkg.
`default_nettype none
module btcs_back
    import btcs_pkg::*;
#(
    parameter int unsigned ENTRIES = ENTRIES_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [15:0] generation,
    input  wire logic        q_valid,
    output logic             q_ready,
    input  req_t             q_req,
    output logic             out_valid,
    input  wire logic        out_ready,
    output res_t             out_res
);
    localparam int unsigned ROWS = ENTRIES / 4;
    localparam int unsigned RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

    // One memory row holds a whole cluster of four slots.
    entry_t [3:0] mem [ROWS];

    bstate_t      state_reg, state_next;
    logic [RW:0]  clr_reg, clr_next;
    req_t         req_reg;
    entry_t [3:0] row_reg;
    res_t         res_reg, res_next;
    logic         ovalid_reg, ovalid_next;
    logic         wr_en;
    logic [RW-1:0] wr_addr;
    entry_t [3:0] wr_row;
    logic         take;

    // Lookup and update of the registered cluster.
    logic         found;
    logic [1:0]   slot;
    logic [1:0]   vict;
    logic [23:0]  sc [4];
    logic [23:0]  best;
    entry_t       e, n;
    logic         upd;
    res_t         rr;
    logic [RW-1:0] row_addr;

    always_comb
    begin
        found = 1'b0;
        slot  = 2'd0;
        for (int i = 3; i >= 0; i--)
        begin
            if (row_reg[i].tag == req_reg.tag)
            begin
                found = 1'b1;
                slot  = 2'(i);
            end
        end
        for (int i = 0; i < 4; i++)
        begin
            sc[i] = {5'd0, row_reg[i].date, 3'd0} +
                    {16'd0, (row_reg[i].udep > row_reg[i].ldep) ?
                     row_reg[i].udep : row_reg[i].ldep};
        end
        best = sc[0];
        vict = 2'd0;
        for (int i = 1; i < 4; i++)
        begin
            if (sc[i] < best)
            begin
                best = sc[i];
                vict = 2'(i);
            end
        end
        if (found)
        begin
            vict = slot;
        end
        e = row_reg[vict];
        n = e;
        upd = 1'b0;
        rr  = '0;
        unique case (req_reg.act)
            ACT_PROBE:
            begin
                if (found)
                begin
                    n.date = generation;
                    upd = 1'b1;
                    rr = {1'b1, e.mv, e.lower, e.upper, e.ldep, e.udep};
                end
            end
            ACT_UPPER, ACT_LOWER:
            begin
                upd = 1'b1;
                n.date = generation;
                if (!found)
                begin
                    n.tag = req_reg.tag;
                    if (req_reg.act == ACT_UPPER)
                    begin
                        n.upper = req_reg.value;
                        n.udep  = req_reg.depth;
                        n.lower = '0;
                        n.ldep  = '0;
                        n.mv    = '0;
                    end
                    else
                    begin
                        n.upper = '0;
                        n.udep  = '0;
                        n.lower = req_reg.value;
                        n.ldep  = req_reg.depth;
                        n.mv    = req_reg.mv;
                    end
                end
                else if (req_reg.act == ACT_UPPER)
                begin
                    if (req_reg.depth > e.udep ||
                        (req_reg.depth == e.udep && req_reg.value < e.upper))
                    begin
                        if (e.lower <= req_reg.value)
                        begin
                            n.udep  = req_reg.depth;
                            n.upper = req_reg.value;
                        end
                        else if (e.ldep < req_reg.depth)
                        begin
                            n.udep  = req_reg.depth;
                            n.upper = req_reg.value;
                            n.lower = req_reg.value;
                        end
                    end
                end
                else
                begin
                    if (req_reg.depth > e.ldep ||
                        (req_reg.depth == e.ldep && req_reg.value > e.lower))
                    begin
                        if (req_reg.mv != 16'd0)
                        begin
                            n.mv = req_reg.mv;
                        end
                        if (e.upper >= req_reg.value)
                        begin
                            n.ldep  = req_reg.depth;
                            n.lower = req_reg.value;
                        end
                        else if (e.udep < req_reg.depth)
                        begin
                            n.ldep  = req_reg.depth;
                            n.lower = req_reg.value;
                            n.upper = req_reg.value;
                        end
                    end
                    else if (e.mv == 16'd0)
                    begin
                        n.mv = req_reg.mv;
                    end
                end
                rr = {found, n.mv, n.lower, n.upper, n.ldep, n.udep};
            end
            default:
            begin
                rr = '0;
            end
        endcase
    end

    // Request index bits above the in-cluster slot select the row.
    always_comb
    begin
        if (ROWS > 1)
        begin
            row_addr = req_reg.idx[RW+1:2];
        end
        else
        begin
            row_addr = '0;
        end
    end

    // Sequencer: clearing pass, then read and write of one cluster per request.
    // A result that is being taken in this cycle frees the result register.
    assign take = (state_reg == ST_IDLE) && q_valid && (!ovalid_reg || out_ready);
    assign q_ready = take;

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        ovalid_next = ovalid_reg && !out_ready;
        res_next    = res_reg;
        wr_en       = 1'b0;
        wr_addr     = row_addr;
        wr_row      = row_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg[RW-1:0];
                wr_row  = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (RW+1)'(ROWS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (take)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                wr_en = upd;
                wr_row[vict] = n;
                res_next = rr;
                ovalid_next = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Memory write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_row;
        end
        if (state_reg == ST_READ)
        begin
            row_reg <= mem[row_addr];
        end
        if (take)
        begin
            req_reg <= q_req;
        end
        res_reg <= res_next;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            clr_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign out_valid = ovalid_reg;
    assign out_res   = res_reg;
endmodule
`default_nettype wire

// ===== rtl/bound_table_cluster_store_core.sv =====
// Top level of the bound table cluster store: generation register, front, back.
// Depends on btcs_pkg, btcs_front, btcs_back.
//
// Channel   Dir  Payload
// s_axis    in   tdata: action[1:0] position_key[65:2] bound_value[81:66]
//                       search_depth[89:82] best_move[105:90]
// m_axis    out  tdata: hit, stored_move, lower_bound, upper_bound,
//                       lower_depth, upper_depth
// cfg       in   generation[15:0]
//
// Each item passes through the back part in order: issue, cluster memory read, write.
// The cluster memory holds one four-slot cluster per row.
// After reset a clearing pass over all ENTRIES/4 rows zeroes the memory; the back
// part takes no item meanwhile, though the queue accepts up to two transfers.
// A two-entry queue keeps input ready during back stalls until it is full; a waiting
// result holds the back part until it is taken.
`default_nettype none
module bound_table_cluster_store_core
    import btcs_pkg::*;
#(
    parameter int unsigned ENTRIES = ENTRIES_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // action, position_key, bound_value, search_depth, best_move (low up)
    input  wire logic [111:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // hit, stored_move, lower_bound, upper_bound, lower_depth, upper_depth
    output logic [71:0]       m_axis_tdata,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [15:0]  cfg_data
);
    logic [15:0] gen_reg;
    logic        q_valid, q_ready;
    req_t        q_req;
    res_t        res;
    logic        unused_pad;

    assign cfg_ready = 1'b1;
    assign unused_pad = ^s_axis_tdata[111:106];

    // Generation register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_reg <= '0;
        end
        else if (cfg_valid)
        begin
            gen_reg <= cfg_data;
        end
    end

    btcs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_action (s_axis_tdata[1:0]),
        .in_key    (s_axis_tdata[65:2]),
        .in_value  (s_axis_tdata[81:66]),
        .in_depth  (s_axis_tdata[89:82]),
        .in_move   (s_axis_tdata[105:90]),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_req     (q_req)
    );

    btcs_back #(.ENTRIES(ENTRIES)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .generation (gen_reg),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_req      (q_req),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_res    (res)
    );

    assign m_axis_tdata = {7'd0, res.udep, res.ldep, res.upper, res.lower, res.mv, res.hit};
endmodule
`default_nettype wire

// ===== rtl/btcs_checker.sv =====
// Port-level checker of the bound table cluster store, bound to the top level.
// Depends on bound_table_cluster_store_core.
`default_nettype none
module btcs_checker
(
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [71:0]  m_axis_tdata,
    input wire logic         cfg_ready
);
    // A waiting result holds until taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed while stalled");

    // No result is offered while reset is applied.
    a_rst: assert property (@(posedge clk) !rst_n |-> !m_axis_tvalid)
        else $error("result offered during reset");

    // Pad bits stay zero.
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[71:65] == 7'd0)
        else $error("pad bits set");

    // Configuration is always taken.
    a_cfg: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("cfg not ready");
endmodule

bind bound_table_cluster_store_core btcs_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_ready     (cfg_ready)
);
`default_nettype wire

// ===== tb/tb_bound_table_cluster_store_core.sv =====
// Self-checking testbench for bound_table_cluster_store_core.
// Needs btcs_pkg and the core; drives item and generation transfers and checks each result
// against a behavioral copy of the four-way bound table, or a typed result where chk is set.
`timescale 1ns / 1ps
`default_nettype none
module tb_bound_table_cluster_store_core;
    import btcs_pkg::*;

    localparam int unsigned TBL_ENTRIES = 4096;
    localparam int unsigned WATCHDOG_LIMIT = 20000;
    localparam int unsigned RANDOM_PER_PHASE = 212;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned DRAIN_CYCLES = 12;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [71:0]  m_axis_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [15:0]  cfg_data;

    // Directed stimulus row; a typed result is used only where chk is set.
    typedef struct {
        action_t     act;
        logic [63:0] key;
        logic [15:0] value;
        logic [7:0]  depth;
        logic [15:0] mv;
        bit          chk;
        res_t        res;
    } row_t;

    entry_t      bound_table[TBL_ENTRIES];
    logic [15:0] cur_generation;
    res_t        pending_results[$];
    int unsigned sender_idle_pct;
    int unsigned receiver_stall_pct;
    bit          hold_request;
    bit          failed;
    int unsigned quiet_cycles;
    logic [31:0] pool_hi[6];
    logic [31:0] pool_tag[10];

    bound_table_cluster_store_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
    end
    always #10 clk = ~clk;

    // Applies one item to the table copy and returns the result it causes.
    function automatic res_t table_access(action_t act, logic [63:0] key,
                                          logic signed [15:0] v, logic [7:0] d,
                                          logic [15:0] mv);
        int unsigned base;
        int unsigned slot;
        int unsigned victim;
        int unsigned best;
        int unsigned score;
        int unsigned deepest;
        bit          found;
        entry_t      e;
        res_t        r;
        r = '0;
        found = 1'b0;
        best = 0;
        if (act == ACT_NONE)
            return r;
        base = key[63:32] & (TBL_ENTRIES - 4);
        victim = base;
        for (int i = 0; i < 4; i++)
        begin
            slot = base + i;
            if (bound_table[slot].tag == key[31:0])
            begin
                found = 1'b1;
                victim = slot;
                break;
            end
            deepest = (bound_table[slot].udep > bound_table[slot].ldep) ?
                      bound_table[slot].udep : bound_table[slot].ldep;
            score = (int'(bound_table[slot].date) << 3) + deepest;
            if (i == 0 || score < best)
            begin
                best = score;
                victim = slot;
            end
        end
        e = bound_table[victim];
        if (act == ACT_PROBE && !found)
            return r;
        e.date = cur_generation;
        if (act == ACT_UPPER && found)
        begin
            if (d > e.udep || (d == e.udep && v < e.upper))
            begin
                if (e.lower <= v)
                begin
                    e.udep = d;
                    e.upper = v;
                end
                else if (e.ldep < d)
                begin
                    e.udep = d;
                    e.upper = v;
                    e.lower = v;
                end
            end
        end
        else if (act == ACT_LOWER && found)
        begin
            if (d > e.ldep || (d == e.ldep && v > e.lower))
            begin
                if (mv != 0)
                    e.mv = mv;
                if (e.upper >= v)
                begin
                    e.ldep = d;
                    e.lower = v;
                end
                else if (e.udep < d)
                begin
                    e.ldep = d;
                    e.lower = v;
                    e.upper = v;
                end
            end
            else if (e.mv == 0)
            begin
                e.mv = mv;
            end
        end
        else if (act == ACT_UPPER)
        begin
            e.tag = key[31:0];
            e.upper = v;
            e.udep = d;
            e.lower = '0;
            e.ldep = '0;
            e.mv = '0;
        end
        else if (act == ACT_LOWER)
        begin
            e.tag = key[31:0];
            e.upper = '0;
            e.udep = '0;
            e.lower = v;
            e.ldep = d;
            e.mv = mv;
        end
        bound_table[victim] = e;
        r.hit = found;
        r.mv = e.mv;
        r.lower = e.lower;
        r.upper = e.upper;
        r.ldep = e.ldep;
        r.udep = e.udep;
        return r;
    endfunction

    // Offers one item and waits for its transfer; the result is queued at acceptance.
    task automatic send_item(action_t act, logic [63:0] key, logic [15:0] value,
                             logic [7:0] depth, logic [15:0] mv, bit chk, res_t typed);
        res_t predicted;
        if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct)
                @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, mv, depth, value, key, act};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predicted = table_access(act, key, value, depth, mv);
        pending_results.push_back(chk ? typed : predicted);
    endtask

    // Writes the generation register once the block has drained.
    task automatic write_generation(logic [15:0] gen);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= gen;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cur_generation = gen;
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial
    begin
        int unsigned held;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                m_axis_tready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(posedge clk);
                hold_request = 1'b0;
            end
            m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Result checking against the oldest expectation.
    always @(posedge clk)
    begin
        res_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transfer with no expectation: %h", m_axis_tdata);
                failed = 1'b1;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tdata[0] !== want.hit)
                begin
                    $error("hit: expected %0d, got %0d", want.hit, m_axis_tdata[0]);
                    failed = 1'b1;
                end
                if (m_axis_tdata[16:1] !== want.mv)
                begin
                    $error("stored_move: expected %h, got %h", want.mv, m_axis_tdata[16:1]);
                    failed = 1'b1;
                end
                if (m_axis_tdata[32:17] !== want.lower)
                begin
                    $error("lower_bound: expected %0d, got %0d", want.lower,
                           $signed(m_axis_tdata[32:17]));
                    failed = 1'b1;
                end
                if (m_axis_tdata[48:33] !== want.upper)
                begin
                    $error("upper_bound: expected %0d, got %0d", want.upper,
                           $signed(m_axis_tdata[48:33]));
                    failed = 1'b1;
                end
                if (m_axis_tdata[56:49] !== want.ldep)
                begin
                    $error("lower_depth: expected %0d, got %0d", want.ldep,
                           m_axis_tdata[56:49]);
                    failed = 1'b1;
                end
                if (m_axis_tdata[64:57] !== want.udep)
                begin
                    $error("upper_depth: expected %0d, got %0d", want.udep,
                           m_axis_tdata[64:57]);
                    failed = 1'b1;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** bound_table_cluster_store_core: FAILED **");
            $finish;
        end
    end

    // Main stimulus sequence.
    initial
    begin
        row_t        rows[$];
        row_t        rw;
        int unsigned idle_modes[4];
        int unsigned stall_modes[4];
        logic [15:0] gens[4];
        logic [63:0] key;
        logic [31:0] hi;
        logic [7:0]  depth;
        logic [15:0] mv;
        int unsigned pick;
        action_t     act;

        idle_modes = '{0, 73, 0, 16};
        stall_modes = '{0, 0, 73, 16};
        gens = '{16'hFFFF, 16'h0000, 16'($urandom), 16'h0001};
        for (int i = 0; i < TBL_ENTRIES; i++)
            bound_table[i] = '0;
        cur_generation = '0;
        failed = 1'b0;
        quiet_cycles = 0;
        hold_request = 1'b0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;

        // Key pools: a few clusters, including the first and the last.
        pool_hi[0] = 32'h0000_0000;
        pool_hi[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 6; i++)
            pool_hi[i] = $urandom;
        pool_tag[0] = 32'h0000_0000;
        pool_tag[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 10; i++)
            pool_tag[i] = $urandom;

        // Directed rows: extremes, every action, empty slots, contradictions, replacement.
        rows.push_back('{ACT_PROBE, 64'h0000_0000_0000_1234, 16'd0, 8'd0, 16'd0, 1'b1, '0});
        rows.push_back('{ACT_PROBE, 64'h0000_0010_0000_0000, 16'd0, 8'd0, 16'd0, 1'b1,
                         '{1'b1, 16'd0, 16'sd0, 16'sd0, 8'd0, 8'd0}});
        rows.push_back('{ACT_NONE, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 8'hFF, 16'hFFFF,
                         1'b1, '0});
        rows.push_back('{ACT_UPPER, 64'h0000_0000_FFFF_FFFF, 16'h8000, 8'd255, 16'hFFFF,
                         1'b1, '{1'b0, 16'd0, 16'sd0, -16'sd32768, 8'd0, 8'd255}});
        rows.push_back('{ACT_LOWER, 64'hFFFF_FFFF_ABCD_0001, 16'h7FFF, 8'd255, 16'hFFFF,
                         1'b1, '{1'b0, 16'hFFFF, 16'sd32767, 16'sd0, 8'd255, 8'd0}});
        rows.push_back('{ACT_PROBE, 64'h0000_0000_FFFF_FFFF, 16'd0, 8'd0, 16'd0, 1'b1,
                         '{1'b0 | 1'b1, 16'd0, 16'sd0, -16'sd32768, 8'd0, 8'd255}});
        rows.push_back('{ACT_LOWER, 64'h0000_0000_FFFF_FFFF, 16'd0, 8'd10, 16'd0, 1'b0, '0});
        rows.push_back('{ACT_UPPER, 64'h0000_0000_FFFF_FFFF, 16'h8000, 8'd255, 16'd0,
                         1'b0, '0});
        rows.push_back('{ACT_LOWER, 64'h0000_0000_FFFF_FFFF, 16'd0, 8'd0, 16'd5, 1'b0, '0});
        rows.push_back('{ACT_UPPER, 64'hFFFF_FFFF_ABCD_0001, 16'd100, 8'd1, 16'd0, 1'b0, '0});
        rows.push_back('{ACT_UPPER, 64'hFFFF_FFFF_ABCD_0001, 16'd0, 8'd0, 16'd0, 1'b0, '0});
        rows.push_back('{ACT_LOWER, 64'h0000_0123_5555_0003, 16'd50, 8'd3, 16'd9, 1'b0, '0});
        rows.push_back('{ACT_UPPER, 64'h0000_0123_5555_0003, 16'd10, 8'd5, 16'd0, 1'b0, '0});
        rows.push_back('{ACT_LOWER, 64'h0000_0123_5555_0003, 16'd100, 8'd9, 16'd7, 1'b0, '0});
        rows.push_back('{ACT_UPPER, 64'h0000_0123_5555_0003, 16'h8000, 8'd2, 16'd0, 1'b0, '0});
        rows.push_back('{ACT_LOWER, 64'h0000_0123_5555_0003, 16'd100, 8'd9, 16'd8, 1'b0, '0});
        rows.push_back('{ACT_UPPER, 64'h0000_0123_6666_0001, 16'd1, 8'd7, 16'd0, 1'b0, '0});
        rows.push_back('{ACT_LOWER, 64'h0000_0123_6666_0002, 16'd2, 8'd1, 16'd3, 1'b0, '0});
        rows.push_back('{ACT_UPPER, 64'h0000_0123_6666_0003, 16'd3, 8'd4, 16'd0, 1'b0, '0});
        rows.push_back('{ACT_LOWER, 64'h0000_0123_6666_0004, 16'd4, 8'd1, 16'd0, 1'b0, '0});
        rows.push_back('{ACT_UPPER, 64'h0000_0123_6666_0005, 16'd5, 8'd6, 16'd0, 1'b0, '0});
        rows.push_back('{ACT_PROBE, 64'h0000_0123_6666_0002, 16'd0, 8'd0, 16'd0, 1'b0, '0});
        rows.push_back('{ACT_PROBE, 64'h0000_0123_6666_0004, 16'd0, 8'd0, 16'd0, 1'b0, '0});

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (rows[i])
        begin
            rw = rows[i];
            send_item(rw.act, rw.key, rw.value, rw.depth, rw.mv, rw.chk, rw.res);
        end

        // Random phases, one generation setting and one idling mode each.
        for (int ph = 0; ph < 4; ph++)
        begin
            write_generation(gens[ph]);
            sender_idle_pct = idle_modes[ph];
            receiver_stall_pct = stall_modes[ph];
            if (ph == 0)
                hold_request = 1'b1;
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                pick = $urandom_range(99);
                if (pick < 88)
                begin
                    hi = pool_hi[$urandom_range(5)];
                    hi = {$urandom_range(1) ? hi[31:12] : 20'($urandom), hi[11:2],
                          2'($urandom)};
                    key = {hi, pool_tag[$urandom_range(9)]};
                end
                else
                begin
                    key = {$urandom, $urandom};
                end
                depth = $urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(6));
                mv = $urandom_range(3) == 0 ? 16'd0 : 16'($urandom);
                if (pick >= 96)
                    act = ACT_NONE;
                else
                    act = action_t'($urandom_range(2));
                send_item(act, key, 16'($urandom), depth, mv, 1'b0, '0);
            end
            sender_idle_pct = 0;
        end
        s_axis_tvalid <= 1'b0;

        // Drain and report.
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (!failed)
            $display("** bound_table_cluster_store_core: PASSED **");
        else
            $display("** bound_table_cluster_store_core: FAILED **");
        $finish;
    end
endmodule
`default_nettype wire
